>>> hdl/hcft_pkg.sv
// Shared types and constants for the header compression flow table.
`timescale 1ns / 1ps
package hcft_pkg;

  localparam int FLOW_SLOTS  = 64;
  localparam int ADDR_W      = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CNT_W       = $clog2(FLOW_SLOTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [3:0]  IP_V4     = 4'd4;
  localparam logic [15:0] MIN_LEN   = 16'd40;
  localparam logic [6:0]  IP_HDR    = 7'd20;
  // transport header length minus the 4-byte compressed header
  localparam logic [6:0]  TCP_NET   = 7'd16;
  localparam logic [6:0]  UDP_NET   = 7'd4;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] OUT_REJECT = 2'd0;
  localparam logic [1:0] OUT_NEW    = 2'd1;
  localparam logic [1:0] OUT_COMP   = 2'd2;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] ports;
    logic [7:0]  proto;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] count;
    logic [31:0] saved;
  } entry_t;

  typedef struct packed {
    logic        reject;
    key_t        key;
    logic [15:0] len;
    logic [6:0]  gain;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

>>> hdl/hcft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hcft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/hcft_front.sv
// Front end: header eligibility check, compressed-size math and the item queue.
`timescale 1ns / 1ps
module hcft_front import hcft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] pkt_len,
  input  logic [3:0]  ip_version,
  input  logic [3:0]  ihl_words,
  input  logic [7:0]  proto,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] sport,
  input  logic [15:0] dport,
  input  logic        pop,
  output queue_head_t head
);
  item_t             item_in;
  logic [6:0]        ihl_bytes;
  logic              is_tcp;
  logic              push;
  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    ihl_bytes = {1'b0, ihl_words, 2'b00};
    is_tcp    = (proto == PROTO_TCP);
    item_in.key.src_ip = src_ip;
    item_in.key.dst_ip = dst_ip;
    item_in.key.ports  = {sport, dport};
    item_in.key.proto  = proto;
    item_in.len        = pkt_len;
    item_in.gain       = ihl_bytes + (is_tcp ? TCP_NET : UDP_NET);
    item_in.reject     = (pkt_len < MIN_LEN) || (ip_version != IP_V4) ||
                         (pkt_len < 16'(ihl_bytes + IP_HDR)) ||
                         (!is_tcp && proto != PROTO_UDP);
  end

  assign busy       = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head.valid = (count != '0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      count <= QCNT_W'(count + QCNT_W'(push) - QCNT_W'(pop));
    end
  end
endmodule

>>> hdl/hcft_back.sv
// Back end: table scan for match and eviction victim, context update, result.
`timescale 1ns / 1ps
module hcft_back import hcft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        done,
  output logic [15:0] out_len,
  output logic [1:0]  outcome,
  output logic [5:0]  flow_slot,
  output logic [63:0] total_saved
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t            state;
  item_t             cur;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  rd_idx;
  logic              cmp_vld;
  logic [ADDR_W-1:0] cmp_idx;
  logic              hit_found;
  logic [ADDR_W-1:0] hit_idx;
  logic [31:0]       hit_cnt;
  logic [31:0]       hit_saved;
  logic              vic_found;
  logic [ADDR_W-1:0] vic_idx;
  logic [31:0]       vic_saved;
  logic [31:0]       least;
  logic [63:0]       saved_total;
  entry_t            rdata;
  entry_t            wdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic              has_free;
  logic [31:0]       upd;
  logic              wrap;
  logic [63:0]       tot_hit;
  logic [63:0]       tot_evict;

  assign pop      = (state == S_IDLE) && head.valid;
  assign has_free = (fill != CNT_W'(FLOW_SLOTS));
  assign upd      = hit_saved + 32'(cur.gain);
  assign wrap     = (upd < hit_saved);
  // a wrapped per-flow counter lowers the total by 2^32
  assign tot_hit  = saved_total + {(wrap ? COUNT_MAX : 32'h0), 25'h0, cur.gain};
  assign tot_evict = saved_total - {32'h0, vic_saved};

  always_comb begin
    we    = (state == S_FIN) && (hit_found || has_free || vic_found);
    waddr = hit_found ? hit_idx : (has_free ? fill[ADDR_W-1:0] : vic_idx);
    wdata.key   = cur.key;
    wdata.count = hit_found ? (hit_cnt + 32'd1) : 32'd1;
    wdata.saved = hit_found ? upd : 32'd0;
  end

  hcft_ram #(.WIDTH($bits(entry_t)), .DEPTH(FLOW_SLOTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      saved_total <= '0;
      done        <= 1'b0;
      cmp_vld     <= 1'b0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.item;
            if (head.item.reject) begin
              done        <= 1'b1;
              out_len     <= '0;
              outcome     <= OUT_REJECT;
              flow_slot   <= '0;
              total_saved <= saved_total;
            end else begin
              state     <= S_SCAN;
              rd_idx    <= '0;
              hit_found <= 1'b0;
              vic_found <= 1'b0;
              least     <= COUNT_MAX;
            end
          end
        end
        S_SCAN: begin
          if (rd_idx != fill && !hit_found) begin
            rd_idx  <= CNT_W'(rd_idx + 1'b1);
            cmp_vld <= 1'b1;
            cmp_idx <= rd_idx[ADDR_W-1:0];
          end
          if (cmp_vld && !hit_found) begin
            if (rdata.key == cur.key) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_cnt   <= rdata.count;
              hit_saved <= rdata.saved;
            end else if (rdata.count < least) begin
              least     <= rdata.count;
              vic_found <= 1'b1;
              vic_idx   <= cmp_idx;
              vic_saved <= rdata.saved;
            end
          end
          if (!cmp_vld && (rd_idx == fill || hit_found)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (hit_found) begin
            out_len     <= cur.len - 16'(cur.gain);
            outcome     <= OUT_COMP;
            flow_slot   <= 6'(hit_idx);
            saved_total <= tot_hit;
            total_saved <= tot_hit;
          end else if (has_free) begin
            out_len     <= cur.len;
            outcome     <= OUT_NEW;
            flow_slot   <= 6'(fill[ADDR_W-1:0]);
            fill        <= CNT_W'(fill + 1'b1);
            total_saved <= saved_total;
          end else if (vic_found) begin
            out_len     <= cur.len;
            outcome     <= OUT_NEW;
            flow_slot   <= 6'(vic_idx);
            saved_total <= tot_evict;
            total_saved <= tot_evict;
          end else begin
            out_len     <= '0;
            outcome     <= OUT_REJECT;
            flow_slot   <= '0;
            total_saved <= saved_total;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

>>> hdl/header_compress_flow_table.sv
// Top level of the header compression flow table.
`timescale 1ns / 1ps
// Usage:
//   Input channel: a parsed IPv4 header transaction is taken on a rising edge
//   with start high and busy low. busy is high only while the two-entry queue
//   between the front end and the table engine is full.
//   Result channel: one result per header, shown for one cycle with done
//   high. The receiver cannot stall; results leave in input order.
//   Headers that fail the eligibility check pass from the queue straight to
//   the result when the engine is idle, and never touch the table.
//   Eligible headers scan the context table through one RAM read port, one
//   entry per cycle, over the contexts allocated so far (stopping at a
//   match, after reading one entry past it when there is one). A full table
//   holds 64 contexts. Rejected headers skip the scan; the queue lets new
//   headers be taken while the scan runs.
//   Reset (synchronous rst) empties the queue, marks every context free by
//   clearing the fill count, and zeros the running saved-bytes total. No
//   clearing pass is needed: free contexts are never read.
module header_compress_flow_table import hcft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] pkt_len,
  input  logic [3:0]  ip_version,
  input  logic [3:0]  ihl_words,
  input  logic [7:0]  proto,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] sport,
  input  logic [15:0] dport,
  output logic        done,
  output logic [15:0] out_len,
  output logic [1:0]  outcome,
  output logic [5:0]  flow_slot,
  output logic [63:0] total_saved
);
  queue_head_t head;
  logic        pop;

  // classification and queueing
  hcft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pkt_len    (pkt_len),
    .ip_version (ip_version),
    .ihl_words  (ihl_words),
    .proto      (proto),
    .src_ip     (src_ip),
    .dst_ip     (dst_ip),
    .sport      (sport),
    .dport      (dport),
    .pop        (pop),
    .head       (head)
  );

  // context lookup, allocation / eviction and counters
  hcft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .out_len     (out_len),
    .outcome     (outcome),
    .flow_slot   (flow_slot),
    .total_saved (total_saved)
  );
endmodule

>>> hdl/hcft_checker.sv
// Port-level checks for the header compression flow table.
`timescale 1ns / 1ps
module hcft_checker import hcft_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [15:0] out_len,
  input logic [1:0]  outcome,
  input logic [5:0]  flow_slot
);
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    done && outcome == OUT_REJECT |-> out_len == '0 && flow_slot == '0)
    else $error("rejected result with nonzero length or slot");

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> outcome == OUT_REJECT || outcome == OUT_NEW || outcome == OUT_COMP)
    else $error("undefined outcome code");

  a_new_len: assert property (@(posedge clk) disable iff (rst)
    done && outcome == OUT_NEW |-> out_len >= MIN_LEN)
    else $error("new flow shorter than minimum header");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");
endmodule

bind header_compress_flow_table hcft_checker u_hcft_checker (
  .clk       (clk),
  .rst       (rst),
  .done      (done),
  .out_len   (out_len),
  .outcome   (outcome),
  .flow_slot (flow_slot)
);

>>> test/tb_header_compress_flow_table.sv
// Testbench for the header compression flow table: directed table plus random flows.
`timescale 1ns / 1ps
module tb_header_compress_flow_table;
  import hcft_pkg::*;

  localparam int N_RANDOM = 1030;
  localparam int POOL_SZ  = 96;   // more flows than contexts, so evictions happen

  typedef struct {
    logic [15:0] len;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_t;

  typedef struct {
    logic [15:0] len;
    logic [1:0]  outcome;
    logic [5:0]  slot;
    logic [63:0] total;
  } res_t;

  typedef struct {
    hdr_t h;
    bit   typed;   // expected result written in the row
    res_t r;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [15:0] pkt_len = 0;
  logic [3:0]  ip_version = 0;
  logic [3:0]  ihl_words = 0;
  logic [7:0]  proto = 0;
  logic [31:0] src_ip = 0;
  logic [31:0] dst_ip = 0;
  logic [15:0] sport = 0;
  logic [15:0] dport = 0;
  logic        done;
  logic [15:0] out_len;
  logic [1:0]  outcome;
  logic [5:0]  flow_slot;
  logic [63:0] total_saved;

  header_compress_flow_table u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // shadow copy of the context table
  bit          ctx_valid [FLOW_SLOTS];
  logic [31:0] ctx_sip   [FLOW_SLOTS];
  logic [31:0] ctx_dip   [FLOW_SLOTS];
  logic [31:0] ctx_ports [FLOW_SLOTS];
  logic [7:0]  ctx_proto [FLOW_SLOTS];
  logic [31:0] ctx_count [FLOW_SLOTS];
  logic [31:0] ctx_saved [FLOW_SLOTS];
  logic [63:0] saved_sum;

  res_t pending_results[$];
  int   errors = 0;
  int   burst_left = 0;
  hdr_t flow_pool[POOL_SZ];
  row_t rows[$];

  // Updates the shadow table for one header and returns the result it should produce.
  function automatic res_t compress_header(hdr_t h);
    res_t        r;
    logic [31:0] ihl_b, ports, least, gain, old;
    int          hit, victim;
    ihl_b = h.ihl * 4;
    ports = {h.sport, h.dport};
    r = '{16'd0, OUT_REJECT, 6'd0, saved_sum};
    if (h.len < MIN_LEN || h.ver != IP_V4 || 32'(h.len) < ihl_b + 20 ||
        (h.proto != PROTO_TCP && h.proto != PROTO_UDP))
      return r;
    hit = -1;
    for (int i = 0; i < FLOW_SLOTS; i++)
      if (hit < 0 && ctx_valid[i] && ctx_sip[i] == h.sip && ctx_dip[i] == h.dip &&
          ctx_ports[i] == ports && ctx_proto[i] == h.proto)
        hit = i;
    if (hit < 0) begin
      // free slot first, else least-used unsaturated context, lowest index on tie
      victim = -1;
      least = COUNT_MAX;
      for (int i = 0; i < FLOW_SLOTS; i++) begin
        if (!ctx_valid[i]) begin
          victim = i;
          break;
        end
        if (ctx_count[i] < least) begin
          least = ctx_count[i];
          victim = i;
        end
      end
      if (victim < 0) return r;  // table full and saturated
      if (ctx_valid[victim]) saved_sum -= 64'(ctx_saved[victim]);
      ctx_valid[victim] = 1;
      ctx_sip[victim]   = h.sip;
      ctx_dip[victim]   = h.dip;
      ctx_ports[victim] = ports;
      ctx_proto[victim] = h.proto;
      ctx_count[victim] = 1;
      ctx_saved[victim] = 0;
      r = '{h.len, OUT_NEW, 6'(victim), saved_sum};
      return r;
    end
    gain = ihl_b + ((h.proto == PROTO_TCP) ? 32'd20 : 32'd8) - 32'd4;
    old = ctx_saved[hit];
    ctx_count[hit] += 1;
    ctx_saved[hit] = old + gain;
    saved_sum = saved_sum - 64'(old) + 64'(ctx_saved[hit]);
    r = '{16'(32'(h.len) - gain), OUT_COMP, 6'(hit), saved_sum};
    return r;
  endfunction

  // Drives one header and holds it until the block takes it.
  task automatic send_header(hdr_t h, bit typed, res_t typed_res);
    res_t p;
    start      <= 1;
    pkt_len    <= h.len;
    ip_version <= h.ver;
    ihl_words  <= h.ihl;
    proto      <= h.proto;
    src_ip     <= h.sip;
    dst_ip     <= h.dip;
    sport      <= h.sport;
    dport      <= h.dport;
    do @(posedge clk); while (busy);
    p = compress_header(h);
    pending_results.push_back(typed ? typed_res : p);
    // bursty sender: drop start only between bursts
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  endtask

  function automatic hdr_t random_header();
    hdr_t h;
    int   sel;
    if ($urandom_range(0, 99) < 80) begin
      // mostly a known flow, with a skew so counts differ between contexts
      sel = ($urandom_range(0, 2) == 0) ? $urandom_range(0, POOL_SZ - 1)
                                        : $urandom_range(0, 40);
      h = flow_pool[sel];
      h.ver = IP_V4;
      h.ihl = 4'($urandom_range(0, 15));
      h.len = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(80, 1500));
      if ($urandom_range(0, 20) == 0) h.len = 16'(h.ihl * 4 + 20);
      if (h.len < MIN_LEN) h.len = MIN_LEN + 16'($urandom_range(0, 60));
    end else begin
      // noise: any field combination, mostly rejected
      h.len   = 16'($urandom_range(0, 65535));
      h.ver   = 4'($urandom_range(0, 15));
      h.ihl   = 4'($urandom_range(0, 15));
      h.proto = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                     : ($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
      h.sip   = $urandom;
      h.dip   = $urandom;
      h.sport = 16'($urandom_range(0, 65535));
      h.dport = 16'($urandom_range(0, 65535));
    end
    return h;
  endfunction

  function automatic void add_row(hdr_t h, bit typed, res_t r);
    row_t w;
    w.h = h;
    w.typed = typed;
    w.r = r;
    rows.push_back(w);
  endfunction

  // result checker: the block cannot stall results, so check every done strobe
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction len=%0d outcome=%0d slot=%0d total=%0d",
                 $time, out_len, outcome, flow_slot, total_saved);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_len !== e.len) begin
          $display("%0t: out_len expected %0d actual %0d", $time, e.len, out_len);
          errors++;
        end
        if (outcome !== e.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, e.outcome, outcome);
          errors++;
        end
        if (flow_slot !== e.slot) begin
          $display("%0t: flow_slot expected %0d actual %0d", $time, e.slot, flow_slot);
          errors++;
        end
        if (total_saved !== e.total) begin
          $display("%0t: total_saved expected %0d actual %0d", $time, e.total,
                   total_saved);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    hdr_t h;
    res_t rej, none;
    int   wait_cnt;
    foreach (ctx_valid[i]) ctx_valid[i] = 0;
    saved_sum = 0;
    rej  = '{16'd0, OUT_REJECT, 6'd0, 64'd0};
    none = rej;
    for (int i = 0; i < POOL_SZ; i++) begin
      flow_pool[i].sip   = $urandom;
      flow_pool[i].dip   = $urandom;
      flow_pool[i].sport = 16'($urandom_range(0, 65535));
      flow_pool[i].dport = 16'($urandom_range(0, 65535));
      flow_pool[i].proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    end

    // directed rows: rejections first, while the total is still zero
    h = '{16'd39, IP_V4, 4'd5, PROTO_TCP, 32'h1, 32'h2, 16'd1, 16'd2};
    add_row(h, 1, rej);                                  // too short
    h.len = 40; h.ver = 4'd6;
    add_row(h, 1, rej);                                  // not IPv4
    h.len = 79; h.ver = IP_V4; h.ihl = 4'd15;
    add_row(h, 1, rej);                                  // shorter than IP header + 20
    h.len = 100; h.ihl = 4'd5; h.proto = 8'd1;
    add_row(h, 1, rej);                                  // neither TCP nor UDP
    add_row('{16'd0, 4'd0, 4'd0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0}, 1, rej);
    add_row('{16'hFFFF, 4'hF, 4'hF, 8'hFF, '1, '1, '1, '1}, 1, rej);
    // first flow lands in slot 0 with full length
    h = '{16'hFFFF, IP_V4, 4'd5, PROTO_TCP, '1, '1, '1, '1};
    add_row(h, 1, '{16'hFFFF, OUT_NEW, 6'd0, 64'd0});
    add_row(h, 0, none);                                 // TCP hit
    h.len = 80; h.ihl = 4'd15;
    add_row(h, 0, none);                                 // hit, largest IP header
    h = '{16'd40, IP_V4, 4'd5, PROTO_UDP, 32'd0, 32'd0, 16'd0, 16'd0};
    add_row(h, 0, none);                                 // new UDP flow, slot 1
    add_row(h, 0, none);                                 // UDP hit, minimum length
    h.ihl = 4'd0;
    add_row(h, 0, none);                                 // hit with zero IHL
    h.proto = PROTO_TCP;
    add_row(h, 0, none);                                 // same tuple, other protocol
    h.len = 65535; h.ihl = 4'd0;
    add_row(h, 0, none);
    h = '{16'd41, IP_V4, 4'd5, PROTO_UDP, 32'hA5A5A5A5, 32'h5A5A5A5A, 16'h8000, 16'h0001};
    add_row(h, 0, none);
    h.sport = 16'h0001; h.dport = 16'h8000;
    add_row(h, 0, none);                                 // swapped ports: distinct flow

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send_header(rows[i].h, rows[i].typed, rows[i].r);

    for (int n = 0; n < N_RANDOM; n++) begin
      // drain once midway so the block runs empty between transactions
      if (n == N_RANDOM / 2) begin
        start <= 0;
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000) begin
          @(posedge clk);
          wait_cnt++;
        end
      end
      send_header(random_header(), 0, none);
    end
    start <= 0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
hdl/hcft_pkg.sv
hdl/hcft_ram.sv
hdl/hcft_front.sv
hdl/hcft_back.sv
hdl/header_compress_flow_table.sv
hdl/hcft_checker.sv
test/tb_header_compress_flow_table.sv
